### hdl/ffrm_pkg.sv
// Shared types and constants for the first-fit resource map allocator.
package ffrm_pkg;

  // Width of the address and length fields carried on the item channels.
  localparam int DATA_W = 24;

  // Request item: allocate or free an extent.
  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] length;
    logic [DATA_W-1:0] base;
  } req_t;

  // Response item: one per request.
  typedef struct packed {
    logic [DATA_W-1:0] alloc_base;
    logic              found;
    logic              overflow;
  } rsp_t;

  // Request type codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_ALLOC_UPD,
    CMD_EVAL,
    CMD_MERGE,
    CMD_WR_PREV,
    CMD_WR_NEXT,
    CMD_OVF,
    CMD_DN_INIT,
    CMD_DN,
    CMD_UP_INIT,
    CMD_UP,
    CMD_PUBLISH
  } cmd_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_UPD,
    ST_EVAL,
    ST_DECIDE,
    ST_MERGE,
    ST_WR_PREV,
    ST_WR_NEXT,
    ST_OVF,
    ST_DN_INIT,
    ST_DN,
    ST_UP_INIT,
    ST_UP,
    ST_DONE
  } state_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_free;
    logic hit;
    logic drained;
    logic up_done;
    logic zero_len;
    logic tp;
    logic tn;
    logic size_zero;
    logic full;
    logic out_free;
  } sts_t;

endpackage

### hdl/ffrm_ctrl.sv
// Controller state machine that sequences scans, updates and table shifts.
module ffrm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ffrm_pkg::sts_t   sts,
  output ffrm_pkg::cmd_t   cmd
);
  import ffrm_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit || sts.drained) begin
          if (sts.req_free) state_next = ST_EVAL;
          else if (sts.hit) state_next = ST_ALLOC_UPD;
          else state_next = ST_DONE;
        end
      end
      ST_ALLOC_UPD: begin
        state_next = sts.zero_len ? ST_DN_INIT : ST_DONE;
      end
      ST_EVAL: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.tp && sts.tn) state_next = ST_MERGE;
        else if (sts.tp) state_next = ST_WR_PREV;
        else if (sts.tn) state_next = ST_WR_NEXT;
        else if (!sts.size_zero && sts.full) state_next = ST_OVF;
        else if (!sts.size_zero) state_next = ST_UP_INIT;
        else state_next = ST_DONE;
      end
      ST_MERGE:   state_next = ST_WR_PREV;
      ST_WR_PREV: state_next = sts.tn ? ST_DN_INIT : ST_DONE;
      ST_WR_NEXT: state_next = ST_DONE;
      ST_OVF:     state_next = ST_DONE;
      ST_DN_INIT: state_next = ST_DN;
      ST_DN: begin
        if (sts.drained) state_next = ST_DONE;
      end
      ST_UP_INIT: state_next = ST_UP;
      ST_UP: begin
        if (sts.up_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = CMD_NONE;
    case (state)
      ST_IDLE:      cmd = req_valid ? CMD_LOAD : CMD_NONE;
      ST_SCAN:      cmd = CMD_SCAN;
      ST_ALLOC_UPD: cmd = CMD_ALLOC_UPD;
      ST_EVAL:      cmd = CMD_EVAL;
      ST_MERGE:     cmd = CMD_MERGE;
      ST_WR_PREV:   cmd = CMD_WR_PREV;
      ST_WR_NEXT:   cmd = CMD_WR_NEXT;
      ST_OVF:       cmd = CMD_OVF;
      ST_DN_INIT:   cmd = CMD_DN_INIT;
      ST_DN:        cmd = CMD_DN;
      ST_UP_INIT:   cmd = CMD_UP_INIT;
      ST_UP:        cmd = CMD_UP;
      ST_DONE:      cmd = sts.out_free ? CMD_PUBLISH : CMD_NONE;
      default:      cmd = CMD_NONE;
    endcase
  end

  // A new item is taken only while the controller is idle.
  assign req_stall = (state != ST_IDLE);

endmodule

### hdl/ffrm_dpath.sv
// Datapath: extent table memory, scan and shift counters, merge arithmetic, result register.
module ffrm_dpath #(
  parameter int MAP_ENTRIES = 32,
  parameter int ADDR_BITS   = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  ffrm_pkg::req_t   req,
  input  ffrm_pkg::cmd_t   cmd,
  output ffrm_pkg::sts_t   sts,
  input  logic             rsp_stall,
  output logic             rsp_valid,
  output ffrm_pkg::rsp_t   rsp
);
  import ffrm_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int IW = $clog2(MAP_ENTRIES + 1);
  localparam int WW = (ADDR_BITS > DATA_W) ? ADDR_BITS : DATA_W;
  localparam int SW = WW + 1;
  localparam logic [ADDR_BITS-1:0] AMASK = {ADDR_BITS{1'b1}};

  typedef struct packed {
    logic [ADDR_BITS-1:0] b;
    logic [ADDR_BITS-1:0] l;
  } ext_t;

  // Saturate a sum to the largest representable length.
  function automatic logic [ADDR_BITS-1:0] sat(input logic [SW-1:0] v);
    sat = (v > SW'(AMASK)) ? AMASK : v[ADDR_BITS-1:0];
  endfunction

  // Extent table, one write and one registered read per cycle.
  ext_t            mem [MAP_ENTRIES];
  ext_t            rdata;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  ext_t            wdata;

  // Request and working registers.
  logic                 typ;
  logic [DATA_W-1:0]    size;
  logic [ADDR_BITS-1:0] a;
  logic [IW-1:0]        used;
  logic [IW-1:0]        sa;
  logic                 rd_vld;
  logic [AW-1:0]        rd_idx;
  logic [IW-1:0]        pos;
  ext_t                 prev;
  logic                 prev_ok;
  ext_t                 cur;
  logic                 cur_ok;
  logic                 zero_len;
  logic                 tp;
  logic                 tn;
  logic [ADDR_BITS-1:0] sum_p;
  logic [ADDR_BITS-1:0] sum_n;
  logic [DATA_W-1:0]    res_base;
  logic                 res_found;
  logic                 res_ovf;

  // Derived values.
  logic [WW-1:0] base_ext;
  logic [SW-1:0] size_x;
  logic [SW-1:0] a_x;
  logic [SW-1:0] cur_b_x;
  logic [SW-1:0] alloc_b_sum;
  logic [SW-1:0] alloc_l_dif;
  logic [SW-1:0] prev_end;
  logic [SW-1:0] a_end;
  logic [SW-1:0] sum_p_raw;
  logic [SW-1:0] sum_n_raw;
  logic [SW-1:0] sum_m_raw;
  logic [IW-1:0] sa_dec;
  logic [IW-1:0] pos_dec;
  logic [IW-1:0] pos_inc;
  logic [AW-1:0] rd_idx_dec;
  logic [AW-1:0] rd_idx_inc;
  logic          cond;
  logic          hit;
  logic          drained;
  logic          up_done;
  logic          scan_go;
  logic          up_go;

  assign base_ext    = WW'(req.base);
  assign size_x      = SW'(size);
  assign a_x         = SW'(a);
  assign cur_b_x     = SW'(cur.b);
  assign alloc_b_sum = cur_b_x + size_x;
  assign alloc_l_dif = SW'(cur.l) - size_x;
  assign prev_end    = SW'(prev.b) + SW'(prev.l);
  assign a_end       = a_x + size_x;
  assign sum_p_raw   = SW'(prev.l) + size_x;
  assign sum_n_raw   = SW'(cur.l) + size_x;
  assign sum_m_raw   = SW'(sum_p) + SW'(cur.l);
  assign sa_dec      = sa - IW'(1);
  assign pos_dec     = pos - IW'(1);
  assign pos_inc     = pos + IW'(1);
  assign rd_idx_dec  = rd_idx - AW'(1);
  assign rd_idx_inc  = rd_idx + AW'(1);

  // Scan test: a free stops at the first base above its own, an allocate at the first fit.
  assign cond    = typ ? (SW'(rdata.b) > a_x) : (SW'(rdata.l) >= size_x);
  assign hit     = rd_vld && cond;
  assign scan_go = (sa < used);
  assign up_go   = (sa > pos);
  assign drained = !rd_vld && (sa >= used);
  assign up_done = !rd_vld && (sa <= pos);

  // Memory port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Read address: ascending for scans and removals, descending for insertion.
  assign raddr = (cmd == CMD_UP) ? sa_dec[AW-1:0] : sa[AW-1:0];

  // Write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = cur;
    case (cmd)
      CMD_ALLOC_UPD: begin
        we      = !zero_len;
        wdata.b = alloc_b_sum[ADDR_BITS-1:0];
        wdata.l = alloc_l_dif[ADDR_BITS-1:0];
      end
      CMD_WR_PREV: begin
        we      = 1'b1;
        waddr   = pos_dec[AW-1:0];
        wdata.b = prev.b;
        wdata.l = sum_p;
      end
      CMD_WR_NEXT: begin
        we      = 1'b1;
        wdata.b = a;
        wdata.l = sum_n;
      end
      CMD_DN: begin
        we    = rd_vld;
        waddr = rd_idx_dec;
        wdata = rdata;
      end
      CMD_UP: begin
        if (rd_vld) begin
          we    = 1'b1;
          waddr = rd_idx_inc;
          wdata = rdata;
        end else if (up_done) begin
          we      = 1'b1;
          wdata.b = a;
          wdata.l = sat(size_x);
        end
      end
      default: ;
    endcase
  end

  // Control registers: fill count, read-pending flag, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd == CMD_PUBLISH) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (cmd)
        CMD_SCAN: rd_vld <= scan_go;
        CMD_DN: begin
          rd_vld <= scan_go;
          if (drained) used <= used - IW'(1);
        end
        CMD_UP: begin
          rd_vld <= up_go;
          if (up_done) used <= used + IW'(1);
        end
        CMD_PUBLISH: rd_vld <= 1'b0;
        default: rd_vld <= 1'b0;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        typ       <= req.req_type;
        size      <= req.length;
        a         <= base_ext[ADDR_BITS-1:0];
        sa        <= '0;
        pos       <= '0;
        prev_ok   <= 1'b0;
        cur_ok    <= 1'b0;
        res_base  <= '0;
        res_found <= 1'b0;
        res_ovf   <= 1'b0;
      end
      CMD_SCAN: begin
        if (scan_go) begin
          sa     <= sa + IW'(1);
          rd_idx <= sa[AW-1:0];
        end
        if (hit) begin
          cur      <= rdata;
          cur_ok   <= 1'b1;
          pos      <= IW'(rd_idx);
          zero_len <= (SW'(rdata.l) == size_x);
        end else if (rd_vld) begin
          prev    <= rdata;
          prev_ok <= 1'b1;
        end
        if (drained) pos <= used;
      end
      CMD_ALLOC_UPD: begin
        res_base  <= cur_b_x[DATA_W-1:0];
        res_found <= 1'b1;
      end
      CMD_EVAL: begin
        tp    <= prev_ok && (prev_end == a_x);
        tn    <= cur_ok && (a_end == cur_b_x);
        sum_p <= sat(sum_p_raw);
        sum_n <= sat(sum_n_raw);
      end
      CMD_MERGE:   sum_p <= sat(sum_m_raw);
      CMD_OVF:     res_ovf <= 1'b1;
      CMD_DN_INIT: sa <= pos_inc;
      CMD_DN: begin
        if (scan_go) begin
          sa     <= sa + IW'(1);
          rd_idx <= sa[AW-1:0];
        end
      end
      CMD_UP_INIT: sa <= used;
      CMD_UP: begin
        if (up_go) begin
          sa     <= sa_dec;
          rd_idx <= sa_dec[AW-1:0];
        end
      end
      CMD_PUBLISH: begin
        rsp.alloc_base <= res_base;
        rsp.found      <= res_found;
        rsp.overflow   <= res_ovf;
      end
      default: ;
    endcase
  end

  // Status to the controller.
  always_comb begin
    sts.req_free  = (typ == REQ_FREE);
    sts.hit       = hit;
    sts.drained   = drained;
    sts.up_done   = up_done;
    sts.zero_len  = zero_len;
    sts.tp        = tp;
    sts.tn        = tn;
    sts.size_zero = (size == '0);
    sts.full      = (used == IW'(MAP_ENTRIES));
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

endmodule

### hdl/first_fit_resource_map_allocator.sv
// First-fit resource map allocator: top level joining controller and datapath.
//
// The block keeps a sorted list of free extents (base, length) in a table of MAP_ENTRIES
// entries with one read and one write port and serves one item at a time: an allocate takes
// units from the front of the first extent that is large enough, a free merges with its
// neighbors or inserts a new entry (flagging overflow and dropping the free when the table
// is full). The table is empty after reset and is tracked by a fill count, so no clearing
// pass is needed and the block takes items from the first cycle; software frees the initial
// region first. The scan reads one entry per cycle up to the position found, and removing
// or inserting an entry moves each later entry one per cycle from there, so together they
// pass over the live entries once; a merge with both neighbors is the longest case. The
// result waits in an output register, so the next item is accepted while an earlier result
// has not yet been taken; that next item then holds its result until the output register is
// free.
module first_fit_resource_map_allocator #(
  parameter int MAP_ENTRIES = 32,
  parameter int ADDR_BITS   = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ffrm_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ffrm_pkg::rsp_t   rsp
);
  import ffrm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ffrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table and arithmetic.
  ffrm_dpath #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Only one item is in the block at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while another is in progress");

  // A result is moved to the output only when the output register is free.
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_PUBLISH |-> (!rsp_valid || !rsp_stall))
    else $error("result overwrote a waiting result");

  // A successful allocate never reports overflow.
  a_found_no_ovf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> !rsp.overflow)
    else $error("found and overflow both set");

endmodule

### test/first_fit_map_checker.sv
// Result checker for the first-fit resource map allocator: a free-extent table predictor and compare.
`timescale 1ns / 100ps

module first_fit_map_checker #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  ffrm_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  ffrm_pkg::rsp_t rsp,
  output int             errors,
  output int             outstanding
);
  import ffrm_pkg::*;

  localparam logic [DATA_W-1:0] MAX_UNITS = '1;

  // Predicted free-extent table, sorted by base; entries past live_extents read as zero.
  logic [DATA_W-1:0] extent_start [DEPTH];
  logic [DATA_W-1:0] extent_units [DEPTH];
  int                live_extents;

  // Responses the block owes, oldest first.
  rsp_t owed_responses [$];

  // One line per mismatch, and a count.
  task automatic report_mismatch(input string msg);
    $display("%0t: response mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // Merged lengths clamp at the top of the address space.
  function automatic logic [DATA_W-1:0] clamp_units(input logic [DATA_W:0] v);
    return (v > {1'b0, MAX_UNITS}) ? MAX_UNITS : v[DATA_W-1:0];
  endfunction

  // Remove one extent and shift the later ones down.
  function automatic void drop_extent(input int pos);
    for (int i = pos; i + 1 < live_extents; i++) begin
      extent_start[i] = extent_start[i + 1];
      extent_units[i] = extent_units[i + 1];
    end
    live_extents--;
    extent_start[live_extents] = '0;
    extent_units[live_extents] = '0;
  endfunction

  // Open a slot at pos by shifting the later extents up.
  function automatic void add_extent(input int pos, input logic [DATA_W-1:0] b,
                                     input logic [DATA_W-1:0] n);
    for (int i = live_extents; i > pos; i--) begin
      extent_start[i] = extent_start[i - 1];
      extent_units[i] = extent_units[i - 1];
    end
    extent_start[pos] = b;
    extent_units[pos] = n;
    live_extents++;
  endfunction

  // Apply one request to the predicted table and return the response it yields.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t            o;
    logic [DATA_W:0] free_end;
    int              p;
    o = '0;
    free_end = {1'b0, r.base} + {1'b0, r.length};

    // Allocation: first extent that is long enough gives up its front units.
    if (r.req_type == REQ_ALLOC) begin
      for (int i = 0; i < live_extents; i++) begin
        if (extent_units[i] >= r.length) begin
          o.alloc_base = extent_start[i];
          o.found = 1'b1;
          extent_start[i] = extent_start[i] + r.length;
          extent_units[i] = extent_units[i] - r.length;
          if (extent_units[i] == '0) drop_extent(i);
          break;
        end
      end
      return o;
    end

    // Free: find the first extent that starts above the returned base.
    p = 0;
    while (p < live_extents && extent_start[p] <= r.base) p++;

    // Sums are one bit wider, so nothing past the top of the space touches.
    if (p > 0 && {1'b0, extent_start[p - 1]} + {1'b0, extent_units[p - 1]} == {1'b0, r.base})
    begin
      extent_units[p - 1] = clamp_units({1'b0, extent_units[p - 1]} + {1'b0, r.length});
      if (p < live_extents && free_end == {1'b0, extent_start[p]}) begin
        extent_units[p - 1] = clamp_units({1'b0, extent_units[p - 1]} +
                                          {1'b0, extent_units[p]});
        drop_extent(p);
      end
    end else if (p < live_extents && free_end == {1'b0, extent_start[p]}) begin
      extent_start[p] = r.base;
      extent_units[p] = clamp_units({1'b0, extent_units[p]} + {1'b0, r.length});
    end else if (r.length != '0) begin
      if (live_extents >= DEPTH) o.overflow = 1'b1;
      else add_extent(p, r.base, r.length);
    end
    return o;
  endfunction

  // Predict on each accepted request and check each accepted response.
  always @(posedge clk) begin : watch_channels
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        extent_start[i] = '0;
        extent_units[i] = '0;
      end
      live_extents = 0;
      owed_responses.delete();
    end else begin
      if (req_valid && !req_stall) owed_responses.push_back(serve_request(req));
      if (rsp_valid && !rsp_stall) begin
        if (owed_responses.size() == 0) begin
          report_mismatch($sformatf("response item %h with no request waiting", rsp));
        end else begin
          want = owed_responses.pop_front();
          compare_field("alloc_base", rsp.alloc_base, want.alloc_base);
          compare_field("found", DATA_W'(rsp.found), DATA_W'(want.found));
          compare_field("overflow", DATA_W'(rsp.overflow), DATA_W'(want.overflow));
        end
      end
    end
    outstanding = owed_responses.size();
  end

endmodule

### test/first_fit_resource_map_allocator_tb.sv
// Testbench top for the first-fit resource map allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module first_fit_resource_map_allocator_tb;
  import ffrm_pkg::*;

  localparam int MAP_ENTRIES  = 32;
  localparam int ADDR_BITS    = 24;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 120;
  localparam int QUIET_LIMIT  = 5000;

  localparam logic [DATA_W-1:0] MAX_UNITS = '1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  int errors;
  int outstanding;
  int items_sent   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  first_fit_resource_map_allocator #(
    .MAP_ENTRIES(MAP_ENTRIES),
    .ADDR_BITS  (ADDR_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  first_fit_map_checker #(
    .DEPTH(MAP_ENTRIES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .errors     (errors),
    .outstanding(outstanding)
  );

  function automatic req_t free_of(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] n);
    req_t r;
    r.req_type = REQ_FREE;
    r.length = n;
    r.base = b;
    return r;
  endfunction

  // The base field of an allocate is ignored, so it carries noise.
  function automatic req_t alloc_of(input logic [DATA_W-1:0] n);
    req_t r;
    r.req_type = REQ_ALLOC;
    r.length = n;
    r.base = DATA_W'($urandom);
    return r;
  endfunction

  // Mostly frees and allocations on a 16-unit grid near origin, so extents touch,
  // merge, split and fill the table; the rest is full-range noise and extremes.
  function automatic req_t random_item(input logic [DATA_W-1:0] origin, input int free_pct);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.req_type = 1'($urandom_range(0, 1));
      r.length = DATA_W'($urandom);
      r.base = DATA_W'($urandom);
    end else if (pick < 12) begin
      r.req_type = 1'($urandom_range(0, 1));
      r.length = $urandom_range(0, 1) ? MAX_UNITS - DATA_W'($urandom_range(0, 3))
                                      : DATA_W'($urandom_range(0, 3));
      r.base = $urandom_range(0, 1) ? MAX_UNITS - DATA_W'($urandom_range(0, 3))
                                    : DATA_W'($urandom_range(0, 3));
    end else if ($urandom_range(0, 99) < free_pct) begin
      r = free_of(origin + DATA_W'(16 * $urandom_range(0, 255)),
                  ($urandom_range(0, 29) == 0) ? '0 : DATA_W'(16 * $urandom_range(1, 4)));
    end else begin
      r = alloc_of(DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                       : 16 * $urandom_range(1, 6)));
    end
    return r;
  endfunction

  // Offer one item, wait for it to be taken, then either stay in the burst or idle.
  task automatic send(input req_t item);
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Request side: reset, directed items, random phases, then drain and verdict.
  initial begin : stimulus
    logic [DATA_W-1:0] origin;
    int                free_pct;
    origin = '0;
    free_pct = 50;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table: both a real and a zero-unit allocation fail.
    send(alloc_of(24'd5));
    send(alloc_of(24'd0));
    // First region; zero-unit allocation returns its base untouched.
    send(free_of(24'h000100, 24'h000100));
    send(alloc_of(24'd0));
    send(alloc_of(24'h000010));
    // Longer than any extent.
    send(alloc_of(24'h001000));
    // Merge with the next extent, insert after, then close the gap on both sides.
    send(free_of(24'h000100, 24'h000010));
    send(free_of(24'h000300, 24'h000100));
    send(free_of(24'h000200, 24'h000100));
    // Zero-unit frees: one touches the previous extent, one touches nothing.
    send(free_of(24'h000400, 24'h000000));
    send(free_of(24'h000600, 24'h000000));
    // The extent at the top of the space must not touch one at zero.
    send(free_of(24'hFFFF00, 24'h000100));
    send(free_of(24'h000000, 24'h000100));
    send(free_of(24'hFFFFFF, MAX_UNITS));
    // Overlapping frees are sorted in like any other.
    send(free_of(24'h000500, 24'h000080));
    send(free_of(24'h000540, 24'h000040));
    // Exact fit removes the first extent and shifts the rest down.
    send(alloc_of(24'h000400));
    // Saturating insert, then a merge with the next extent that saturates again.
    send(free_of(24'h000700, MAX_UNITS));
    send(free_of(24'h000680, 24'h000080));
    // Allocation that pushes the extent base past the top, then the longest request.
    send(alloc_of(24'hFFFFF0));
    send(alloc_of(MAX_UNITS));
    send(alloc_of(24'h000001));

    // Random phases, each with its own window and mix of frees and allocations.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       origin = '0;
          1:       origin = 24'hFFF000;
          default: origin = DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       free_pct = 25;
          1:       free_pct = 50;
          2:       free_pct = 70;
          default: free_pct = 85;
        endcase
      end
      send(random_item(origin, free_pct));
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Response side: stall patterns of its own, plus one long hold-off that backs up the block.
  initial begin : response_side
    int mode;
    int span;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        @(posedge clk);
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 150);
        for (int k = 0; k < span; k++) begin
          @(posedge clk);
          case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 1);
            2:       rsp_stall <= (k % 4 == 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
          endcase
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
